### rtl/core/gaussian_polar_sampler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian polar sampler
// Each macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_POLAR_SAMPLER_ASSERT_SVH
`define GAUSSIAN_POLAR_SAMPLER_ASSERT_SVH

// cond holds in a cycle -> expr holds in the same cycle
`define GPS_ASSERT_IMP(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// cond holds in a cycle -> expr holds in the next cycle
`define GPS_ASSERT_NXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

### rtl/core/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// Shared constants, types and elaboration-time helpers of the polar sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gps_pkg;

  localparam int UNIFORM_BITS_DEF  = 16;
  localparam int OUT_FRAC_BITS_DEF = 12;

  // fraction bits of the fixed-point log2
  localparam int LOG_FRAC = 24;

  // 2 ln 2 in Q30
  localparam logic [30:0] LN2X2 = 31'd1488522236;

  // sideband that travels with both lanes of the root pipeline
  typedef struct packed {
    logic v;
    logic neg_a;
    logic neg_b;
  } lane_ctl_t;

  // log2 of x >= 1 with LOG_FRAC fraction bits, for constants only
  function automatic logic [63:0] log2_fixed_const(input logic [63:0] x);
    int          top;
    logic [63:0] m;
    logic [63:0] fr;
    logic [63:0] p;
    top = 0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) begin
        top = i;
      end
    end
    if (top >= 31) begin
      m = x >> (top - 31);
    end else begin
      m = x << (31 - top);
    end
    fr = 64'd0;
    for (int i = 0; i < LOG_FRAC; i++) begin
      p  = m * m;
      m  = {31'd0, p[63:31]};
      fr = {fr[62:0], 1'b0};
      if (m[32]) begin
        fr[0] = 1'b1;
        m     = m >> 1;
      end
    end
    return (64'(top) << LOG_FRAC) | fr;
  endfunction

endpackage

### rtl/core/gps_if.sv
// ----------------------------------------------------------------------------
// gps_in_if / gps_out_if
// Valid/ready channels of the polar sampler: uniform pairs in, deviates out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gps_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_uniform;
  logic [15:0] second_uniform;

  modport source (output valid, output first_uniform, output second_uniform, input ready);
  modport sink   (input valid, input first_uniform, input second_uniform, output ready);
endinterface

interface gps_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

### rtl/core/gps_isqrt.sv
// ----------------------------------------------------------------------------
// gps_isqrt
// Two-lane pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gps_isqrt #(
  parameter  int Y_W = 32,
  localparam int R_W = (Y_W + 1) / 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  gps_pkg::lane_ctl_t  in_ctl,
  input  logic [Y_W-1:0]      y_a,
  input  logic [Y_W-1:0]      y_b,
  output gps_pkg::lane_ctl_t  out_ctl,
  output logic [R_W-1:0]      root_a,
  output logic [R_W-1:0]      root_b
);

  localparam int X_W  = 2 * R_W;
  localparam int RM_W = R_W + 2;

  typedef struct packed {
    logic [X_W-1:0]  x;
    logic [RM_W-1:0] rem;
    logic [R_W-1:0]  rt;
  } lane_t;

  typedef struct packed {
    gps_pkg::lane_ctl_t ctl;
    lane_t              a;
    lane_t              b;
  } sq_t;

  // one digit of the restoring square root
  function automatic lane_t root_step(input lane_t p);
    logic [RM_W+1:0] acc;
    logic [RM_W+1:0] trial;
    lane_t           n;
    acc   = {p.rem, p.x[X_W-1 -: 2]};
    trial = (RM_W + 2)'({p.rt, 2'b01});
    n.x   = p.x << 2;
    if (acc >= trial) begin
      n.rem = RM_W'(acc - trial);
      n.rt  = {p.rt[R_W-2:0], 1'b1};
    end else begin
      n.rem = RM_W'(acc);
      n.rt  = {p.rt[R_W-2:0], 1'b0};
    end
    return n;
  endfunction

  sq_t sq_in;
  sq_t sq_r [1:R_W];

  // seed the first stage from the ports
  always_comb begin
    sq_in.ctl   = in_ctl;
    sq_in.a.x   = X_W'(y_a);
    sq_in.a.rem = '0;
    sq_in.a.rt  = '0;
    sq_in.b.x   = X_W'(y_b);
    sq_in.b.rem = '0;
    sq_in.b.rt  = '0;
  end

  // advance one digit per stage, hold on stall
  for (genvar s = 0; s < R_W; s++) begin : g_digit
    sq_t prev;
    sq_t step_nxt;

    if (s == 0) begin : g_first
      assign prev = sq_in;
    end else begin : g_rest
      assign prev = sq_r[s];
    end

    always_comb begin
      step_nxt     = prev;
      step_nxt.a   = root_step(prev.a);
      step_nxt.b   = root_step(prev.b);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[s+1].ctl.v <= 1'b0;
      end else if (en) begin
        sq_r[s+1] <= step_nxt;
      end
    end
  end

  assign out_ctl = sq_r[R_W].ctl;
  assign root_a  = sq_r[R_W].a.rt;
  assign root_b  = sq_r[R_W].b.rt;

endmodule

### rtl/core/gaussian_polar_sampler.sv
// ----------------------------------------------------------------------------
// gaussian_polar_sampler
// Marsaglia polar method in fixed point: uniform pairs in, normal deviates out.
// ----------------------------------------------------------------------------
//
//  channel  dir  transfer when        payload
//  in_ch    in   valid && ready       first_uniform, second_uniform (u16)
//  out_ch   out  valid && ready       sample (s16, Q3.12), last
//
//  One accepted pair gives two deviates on consecutive output transfers; the output
//  pair register holds each pair until its second deviate is taken. A pair passes
//  P1-P7, 33 divide/log steps, PD, PT, PY, R_W root digits (R_W = 16 at default
//  widths) and the output register. Rejected pairs leave the pipe as bubbles.
//  rst_n is synchronous and clears every valid bit; payload is not reset.
//  A stall freezes all stages at once, so nothing is lost or repeated.
//
`timescale 1ns / 1ps
`include "gaussian_polar_sampler_assert.svh"

module gaussian_polar_sampler #(
  parameter int UNIFORM_BITS  = gps_pkg::UNIFORM_BITS_DEF,
  parameter int OUT_FRAC_BITS = gps_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gps_in_if.sink     in_ch,
  gps_out_if.source  out_ch
);

  localparam int UB    = UNIFORM_BITS;
  localparam int UW    = (UB > 16) ? UB : 16;
  localparam int H_W   = 2 * UB;
  localparam int NG    = (H_W + 7) / 8;
  localparam int HP_W  = NG * 8;
  localparam int TOP_W = $clog2(HP_W);
  localparam int LF    = gps_pkg::LOG_FRAC;
  localparam int D_W   = TOP_W + LF;
  localparam int T_W   = D_W + 1;
  localparam int SH    = 32 + LF - 2 * OUT_FRAC_BITS;
  localparam int P_W   = 33 + T_W;
  localparam int Y_W   = P_W - SH;
  localparam int R_W   = (Y_W + 1) / 2;
  localparam int NSTEP = 33;

  localparam logic [UB:0]    M_U  = {1'b0, {UB{1'b1}}};
  localparam logic [H_W-1:0] M_H  = H_W'(M_U);
  localparam logic [H_W-1:0] M2   = M_H * M_H;
  localparam logic [H_W-1:0] HLIM = (M2 >> 1) + H_W'(1);
  localparam logic [63:0]    LM   = gps_pkg::log2_fixed_const(64'(M2));
  localparam logic [D_W-1:0] LMB  = D_W'(LM - (64'd1 << LF));

  typedef struct packed {
    logic             v;
    logic             neg_a;
    logic             neg_b;
    logic [TOP_W-1:0] top;
    logic [31:0]      m;
    logic [LF-1:0]    frac;
    logic [30:0]      den;
    logic [30:0]      rem_a;
    logic [30:0]      rem_b;
    logic [32:0]      q_a;
    logic [32:0]      q_b;
  } chain_t;

  // fold a uniform sample around the midpoint: {sign, |2u - M|}
  function automatic logic [UB:0] fold(input logic [UB-1:0] u);
    logic [UB:0] twou;
    logic        ge;
    twou = {u, 1'b0};
    ge   = (twou >= M_U);
    if (ge) begin
      return {1'b0, UB'(twou - M_U)};
    end
    return {1'b1, UB'(M_U - twou)};
  endfunction

  // sign the root and clamp it to 16 bits
  function automatic logic [15:0] sat16(input logic [R_W-1:0] mag, input logic neg);
    logic [31:0] m32;
    m32 = 32'(mag);
    if (neg) begin
      if (m32 > 32'd32768) begin
        m32 = 32'd32768;
      end
      return 16'(32'd0 - m32);
    end
    if (m32 > 32'd32767) begin
      m32 = 32'd32767;
    end
    return m32[15:0];
  endfunction

  logic adv;

  // ---------------------------------------------------------------- P1: capture
  logic [UW-1:0] ext_a, ext_b;
  logic          p1_v_r;
  logic [UB-1:0] p1_ua_r, p1_ub_r;

  assign ext_a = UW'(in_ch.first_uniform);
  assign ext_b = UW'(in_ch.second_uniform);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_ua_r <= ext_a[UB-1:0];
      p1_ub_r <= ext_b[UB-1:0];
    end
  end

  // ---------------------------------------------------------------- P2: fold
  logic [UB:0]   fa_nxt, fb_nxt;
  logic          p2_v_r, p2_na_r, p2_nb_r;
  logic [UB-1:0] p2_a_r, p2_b_r;

  assign fa_nxt = fold(p1_ua_r);
  assign fb_nxt = fold(p1_ub_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (adv) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_na_r <= fa_nxt[UB];
      p2_nb_r <= fb_nxt[UB];
      p2_a_r  <= fa_nxt[UB-1:0];
      p2_b_r  <= fb_nxt[UB-1:0];
    end
  end

  // ---------------------------------------------------------------- P3: square
  logic [H_W-1:0] a2_nxt, b2_nxt;
  logic           p3_v_r, p3_na_r, p3_nb_r;
  logic [H_W-1:0] p3_a2_r, p3_b2_r;

  assign a2_nxt = H_W'(p2_a_r) * H_W'(p2_a_r);
  assign b2_nxt = H_W'(p2_b_r) * H_W'(p2_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (adv) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_na_r <= p2_na_r;
      p3_nb_r <= p2_nb_r;
      p3_a2_r <= a2_nxt;
      p3_b2_r <= b2_nxt;
    end
  end

  // ---------------------------------------------------------------- P4: radius, reject
  logic [H_W-1:0] a2h_nxt, b2h_nxt, h_nxt;
  logic           rej_nxt;
  logic           p4_v_r, p4_na_r, p4_nb_r;
  logic [H_W-1:0] p4_h_r, p4_a2h_r, p4_b2h_r;

  assign a2h_nxt = p3_a2_r >> 1;
  assign b2h_nxt = p3_b2_r >> 1;
  assign h_nxt   = a2h_nxt + b2h_nxt + H_W'(1);
  assign rej_nxt = (h_nxt >= HLIM) || ((p3_a2_r == '0) && (p3_b2_r == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else if (adv) begin
      p4_v_r <= p3_v_r && !rej_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_na_r  <= p3_na_r;
      p4_nb_r  <= p3_nb_r;
      p4_h_r   <= h_nxt;
      p4_a2h_r <= a2h_nxt;
      p4_b2h_r <= b2h_nxt;
    end
  end

  // ---------------------------------------------------------------- P5: byte scan
  logic [HP_W-1:0]       hp;
  logic [NG-1:0]         nz_nxt;
  logic [NG-1:0][2:0]    pos_nxt;
  logic                  p5_v_r, p5_na_r, p5_nb_r;
  logic [NG-1:0]         p5_nz_r;
  logic [NG-1:0][2:0]    p5_pos_r;
  logic [H_W-1:0]        p5_h_r, p5_a2h_r, p5_b2h_r;

  assign hp = HP_W'(p4_h_r);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      nz_nxt[g]  = (hp[g*8 +: 8] != 8'd0);
      pos_nxt[g] = 3'd0;
      for (int j = 0; j < 8; j++) begin
        if (hp[g*8 + j]) begin
          pos_nxt[g] = 3'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_v_r <= 1'b0;
    end else if (adv) begin
      p5_v_r <= p4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_na_r  <= p4_na_r;
      p5_nb_r  <= p4_nb_r;
      p5_nz_r  <= nz_nxt;
      p5_pos_r <= pos_nxt;
      p5_h_r   <= p4_h_r;
      p5_a2h_r <= p4_a2h_r;
      p5_b2h_r <= p4_b2h_r;
    end
  end

  // ---------------------------------------------------------------- P6: top bit
  logic [TOP_W-1:0] top_nxt;
  logic             p6_v_r, p6_na_r, p6_nb_r;
  logic [TOP_W-1:0] p6_top_r;
  logic [H_W-1:0]   p6_h_r, p6_a2h_r, p6_b2h_r;

  always_comb begin
    top_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      if (p5_nz_r[g]) begin
        top_nxt = TOP_W'(g * 8) + TOP_W'(p5_pos_r[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_v_r <= 1'b0;
    end else if (adv) begin
      p6_v_r <= p5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p6_na_r  <= p5_na_r;
      p6_nb_r  <= p5_nb_r;
      p6_top_r <= top_nxt;
      p6_h_r   <= p5_h_r;
      p6_a2h_r <= p5_a2h_r;
      p6_b2h_r <= p5_b2h_r;
    end
  end

  // ---------------------------------------------------------------- P7: normalize
  logic [TOP_W:0] top_e, msh, k;
  chain_t         seed_nxt;
  chain_t         ch_r [0:NSTEP];

  assign top_e = (TOP_W + 1)'(p6_top_r);
  assign msh   = top_e + (TOP_W + 1)'(1);
  assign k     = (top_e >= (TOP_W + 1)'(31)) ? (top_e - (TOP_W + 1)'(30)) : '0;

  always_comb begin
    seed_nxt.v     = p6_v_r;
    seed_nxt.neg_a = p6_na_r;
    seed_nxt.neg_b = p6_nb_r;
    seed_nxt.top   = p6_top_r;
    seed_nxt.m     = 32'({p6_h_r, 32'd0} >> msh);
    seed_nxt.frac  = '0;
    seed_nxt.den   = 31'(p6_h_r >> k);
    seed_nxt.rem_a = 31'(p6_a2h_r >> k);
    seed_nxt.rem_b = 31'(p6_b2h_r >> k);
    seed_nxt.q_a   = '0;
    seed_nxt.q_b   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r[0].v <= 1'b0;
    end else if (adv) begin
      ch_r[0] <= seed_nxt;
    end
  end

  // ---------------------------------------------------------------- divide and log steps
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    chain_t      step_nxt;
    logic [63:0] sq;
    logic [32:0] sqh;
    logic [31:0] sh_a, sh_b;
    logic [31:0] den_e;
    logic        ge_a, ge_b;

    assign sq    = 64'(ch_r[i].m) * 64'(ch_r[i].m);
    assign sqh   = sq[63:31];
    assign den_e = {1'b0, ch_r[i].den};

    if (i == 0) begin : g_lead
      assign sh_a = {1'b0, ch_r[i].rem_a};
      assign sh_b = {1'b0, ch_r[i].rem_b};
    end else begin : g_body
      assign sh_a = {ch_r[i].rem_a, 1'b0};
      assign sh_b = {ch_r[i].rem_b, 1'b0};
    end

    assign ge_a = (sh_a >= den_e);
    assign ge_b = (sh_b >= den_e);

    always_comb begin
      step_nxt       = ch_r[i];
      step_nxt.rem_a = 31'(ge_a ? (sh_a - den_e) : sh_a);
      step_nxt.rem_b = 31'(ge_b ? (sh_b - den_e) : sh_b);
      step_nxt.q_a   = {ch_r[i].q_a[31:0], ge_a};
      step_nxt.q_b   = {ch_r[i].q_b[31:0], ge_b};
      if (i < LF) begin
        step_nxt.m    = sqh[32] ? sqh[32:1] : sqh[31:0];
        step_nxt.frac = {ch_r[i].frac[LF-2:0], sqh[32]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ch_r[i+1].v <= 1'b0;
      end else if (adv) begin
        ch_r[i+1] <= step_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- PD: -log2 s
  logic [D_W-1:0] lh, d_nxt;
  logic           pd_v_r, pd_na_r, pd_nb_r;
  logic [D_W-1:0] pd_d_r;
  logic [32:0]    pd_qa_r, pd_qb_r;

  assign lh    = {ch_r[NSTEP].top, ch_r[NSTEP].frac};
  assign d_nxt = (LMB >= lh) ? (LMB - lh) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_v_r <= 1'b0;
    end else if (adv) begin
      pd_v_r <= ch_r[NSTEP].v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pd_na_r <= ch_r[NSTEP].neg_a;
      pd_nb_r <= ch_r[NSTEP].neg_b;
      pd_d_r  <= d_nxt;
      pd_qa_r <= ch_r[NSTEP].q_a;
      pd_qb_r <= ch_r[NSTEP].q_b;
    end
  end

  // ---------------------------------------------------------------- PT: -2 ln s
  logic [D_W+30:0] tp;
  logic            pt_v_r, pt_na_r, pt_nb_r;
  logic [T_W-1:0]  pt_t_r;
  logic [32:0]     pt_qa_r, pt_qb_r;

  assign tp = (D_W + 31)'(pd_d_r) * (D_W + 31)'(gps_pkg::LN2X2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_v_r <= 1'b0;
    end else if (adv) begin
      pt_v_r <= pd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt_na_r <= pd_na_r;
      pt_nb_r <= pd_nb_r;
      pt_t_r  <= tp[D_W+30:30];
      pt_qa_r <= pd_qa_r;
      pt_qb_r <= pd_qb_r;
    end
  end

  // ---------------------------------------------------------------- PY: scale
  logic [P_W-1:0]     ya_p, yb_p;
  gps_pkg::lane_ctl_t py_ctl_r;
  logic [Y_W-1:0]     py_ya_r, py_yb_r;

  assign ya_p = P_W'(pt_qa_r) * P_W'(pt_t_r);
  assign yb_p = P_W'(pt_qb_r) * P_W'(pt_t_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      py_ctl_r.v <= 1'b0;
    end else if (adv) begin
      py_ctl_r <= '{v: pt_v_r, neg_a: pt_na_r, neg_b: pt_nb_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      py_ya_r <= ya_p[P_W-1:SH];
      py_yb_r <= yb_p[P_W-1:SH];
    end
  end

  // ---------------------------------------------------------------- square root lanes
  gps_pkg::lane_ctl_t isq_ctl;
  logic [R_W-1:0]     root_a, root_b;

  gps_isqrt #(
    .Y_W (Y_W)
  ) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_ctl  (py_ctl_r),
    .y_a     (py_ya_r),
    .y_b     (py_yb_r),
    .out_ctl (isq_ctl),
    .root_a  (root_a),
    .root_b  (root_b)
  );

  // ---------------------------------------------------------------- output pair register
  logic        hold_v_r, hold_v_nxt;
  logic        phase_r, phase_nxt;
  logic [15:0] samp_a_r, samp_b_r;
  logic        free, load;

  assign free = !hold_v_r || (phase_r && out_ch.ready);
  assign adv  = !isq_ctl.v || free;
  assign load = adv && isq_ctl.v;

  // load a finished pair, else step through its two transfers
  always_comb begin
    hold_v_nxt = hold_v_r;
    phase_nxt  = phase_r;
    if (load) begin
      hold_v_nxt = 1'b1;
      phase_nxt  = 1'b0;
    end else if (hold_v_r && out_ch.ready) begin
      if (phase_r) begin
        hold_v_nxt = 1'b0;
      end else begin
        phase_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      phase_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      samp_a_r <= sat16(root_a, isq_ctl.neg_a);
      samp_b_r <= sat16(root_b, isq_ctl.neg_b);
    end
  end

  assign in_ch.ready  = adv;
  assign out_ch.valid = hold_v_r;
  assign out_ch.last  = phase_r;
  assign out_ch.sample = $signed(phase_r ? samp_b_r : samp_a_r);

  // ---------------------------------------------------------------- checks
  `GPS_ASSERT_NXT(a_second_follows, out_ch.valid && out_ch.ready && !out_ch.last,
                  out_ch.valid && out_ch.last, "second deviate did not follow the first")
  `GPS_ASSERT_IMP(a_ready_when_empty, !hold_v_r, in_ch.ready,
                  "input stalled while output register is empty")
  `GPS_ASSERT_NXT(a_capture, in_ch.valid && in_ch.ready, p1_v_r,
                  "accepted pair not captured in first stage")
  `GPS_ASSERT_NXT(a_stall_holds, !adv, $stable(isq_ctl.v) && isq_ctl.v,
                  "pipeline tail moved during a stall")

endmodule

### verif/tb_gaussian_polar_sampler.sv
// ----------------------------------------------------------------------------
// tb_gaussian_polar_sampler
// Drives uniform pairs into the polar sampler under random idling and stalls,
// predicts every deviate in bit-exact fixed point and checks each transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gaussian_polar_sampler;

  localparam int    N_RANDOM     = 700;
  localparam int    HOLD_CYCLES  = 400;
  localparam int    DRAIN_CYCLES = 200;
  localparam longint BIG_M       = 64'd65535;

  typedef struct {
    logic [15:0] u1;
    logic [15:0] u2;
    bit          drain_first;
  } pair_t;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
  } deviate_t;

  logic clk;
  logic rst_n;

  gps_in_if  in_ch ();
  gps_out_if out_ch ();

  gaussian_polar_sampler u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pair_t    pending_pairs[$];
  deviate_t deviates_due[$];

  int  mismatches;
  bit  failed;
  bit  in_busy;
  bit  in_took;
  bit  out_took;
  int  send_gap;
  int  recv_gap;
  int  hold_left;
  bit  hold_done;
  int  results_seen;
  int  pairs_taken;
  bit  all_sent;

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------- bit-exact deviate predictor ----------------
  function automatic int bit_len(longint unsigned x);
    int n;
    n = 0;
    while (x != 0) begin
      n++;
      x >>= 1;
    end
    return n;
  endfunction

  function automatic longint unsigned log2_q24(longint unsigned x);
    int              top;
    longint unsigned m;
    longint unsigned fr;
    top = bit_len(x) - 1;
    m   = (top >= 31) ? (x >> (top - 31)) : (x << (31 - top));
    fr  = 0;
    for (int i = 0; i < gps_pkg::LOG_FRAC; i++) begin
      m  = (m * m) >> 31;
      fr = fr << 1;
      if (m >= (64'd1 << 32)) begin
        fr = fr | 1;
        m  = m >> 1;
      end
    end
    return (longint'(top) << gps_pkg::LOG_FRAC) | fr;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] scale_deviate(longint unsigned sq, bit neg,
                                                       longint unsigned h, int k,
                                                       longint unsigned t);
    longint unsigned num;
    longint unsigned den;
    longint unsigned c;
    longint unsigned mag;
    num = (sq >> 1) >> k;
    den = h >> k;
    if (den == 0) den = 1;
    c   = (num << 32) / den;
    mag = int_sqrt((c * t) >>
                   (32 + gps_pkg::LOG_FRAC - 2 * gps_pkg::OUT_FRAC_BITS_DEF));
    if (neg) begin
      if (mag > 32768) mag = 32768;
      return 16'(0 - mag);
    end
    if (mag > 32767) mag = 32767;
    return 16'(mag);
  endfunction

  // Queue the deviates that one uniform pair yields; rejected pairs queue nothing
  task automatic predict_pair(logic [15:0] u1, logic [15:0] u2);
    longint unsigned a, b, a2, b2, h, m2, lm, lh, d, t;
    bit              neg_a, neg_b;
    int              k;
    deviate_t        dv;
    neg_a = (2 * longint'(u1) < BIG_M);
    neg_b = (2 * longint'(u2) < BIG_M);
    a  = neg_a ? BIG_M - 2 * longint'(u1) : 2 * longint'(u1) - BIG_M;
    b  = neg_b ? BIG_M - 2 * longint'(u2) : 2 * longint'(u2) - BIG_M;
    a2 = a * a;
    b2 = b * b;
    h  = (a2 >> 1) + (b2 >> 1) + 1;
    m2 = BIG_M * BIG_M;
    if (h >= (m2 >> 1) + 1 || (a2 == 0 && b2 == 0)) return;
    lm = log2_q24(m2);
    lh = log2_q24(h);
    d  = (lm >= lh + (64'd1 << gps_pkg::LOG_FRAC)) ?
         lm - (64'd1 << gps_pkg::LOG_FRAC) - lh : 0;
    t  = (d * longint'(gps_pkg::LN2X2)) >> 30;
    k  = (bit_len(h) > 31) ? bit_len(h) - 31 : 0;
    dv.sample = scale_deviate(a2, neg_a, h, k, t);
    dv.last   = 1'b0;
    deviates_due.insert(deviates_due.size(), dv);
    dv.sample = scale_deviate(b2, neg_b, h, k, t);
    dv.last   = 1'b1;
    deviates_due.insert(deviates_due.size(), dv);
  endtask

  // ---------------- transfer capture and checking ----------------
  always @(posedge clk) begin
    deviate_t exp_dv;
    in_took  <= rst_n && in_ch.valid && in_ch.ready;
    out_took <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_pair(in_ch.first_uniform, in_ch.second_uniform);
      pairs_taken++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (deviates_due.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected deviate %0d last=%0b", out_ch.sample, out_ch.last);
      end else begin
        exp_dv = deviates_due.pop_front();
        if (out_ch.sample !== exp_dv.sample || out_ch.last !== exp_dv.last) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("deviate mismatch: expected %0d/%0b got %0d/%0b",
                     exp_dv.sample, exp_dv.last, out_ch.sample, out_ch.last);
        end
      end
    end
  end

  // ---------------- pair driver ----------------
  always @(negedge clk) begin
    pair_t p;
    bit    busy;
    busy = in_busy;
    if (rst_n) begin
      if (busy && in_took) begin
        busy     = 1'b0;
        // idle-free stretch every other block of 64 pairs
        send_gap = (pairs_taken[6]) ? 0 : $urandom_range(0, 7);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_pairs.size() != 0 &&
                     !(pending_pairs[0].drain_first && deviates_due.size() != 0)) begin
          p = pending_pairs.pop_front();
          in_ch.first_uniform  <= p.u1;
          in_ch.second_uniform <= p.u2;
          in_ch.valid          <= 1'b1;
          busy = 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
          if (pending_pairs.size() == 0) all_sent <= 1'b1;
        end
      end
    end
    in_busy <= busy;
  end

  // ---------------- deviate receiver ----------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) recv_gap = (results_seen[6]) ? 0 : $urandom_range(0, 7);
      // hold off long once, so the pipe fills and stalls its input
      if (!hold_done && results_seen >= 200) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus and end of run ----------------
  task automatic add_pair(logic [15:0] u1, logic [15:0] u2, bit drain_first = 1'b0);
    pair_t p;
    p.u1 = u1;
    p.u2 = u2;
    p.drain_first = drain_first;
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  function automatic logic [15:0] draw_uniform(int mode);
    case (mode)
      0: return 16'($urandom_range(32767 - 40, 32768 + 40));
      1: return 16'($urandom_range(32767 - 4000, 32768 + 4000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int mode;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.first_uniform   = 16'd0;
    in_ch.second_uniform  = 16'd0;
    out_ch.ready          = 1'b0;
    mismatches = 0;   failed = 1'b0;   in_busy = 1'b0;   in_took = 1'b0;
    out_took = 1'b0;  send_gap = 0;    recv_gap = 0;     hold_left = 0;
    hold_done = 1'b0; results_seen = 0; pairs_taken = 0; all_sent = 1'b0;

    // extremes, rejections, near-zero radius and saturation
    add_pair(16'd0, 16'd0);
    add_pair(16'hFFFF, 16'hFFFF);
    add_pair(16'd0, 16'hFFFF);
    add_pair(16'd32767, 16'd32768);
    add_pair(16'd32768, 16'd32767);
    add_pair(16'd32767, 16'd32767);
    add_pair(16'd32768, 16'd32768);
    add_pair(16'd32767, 16'd0);
    add_pair(16'd65535, 16'd32768);
    add_pair(16'd32769, 16'd32766);
    add_pair(16'd40000, 16'd20000);
    add_pair(16'd10000, 16'd50000);
    add_pair(16'd55000, 16'd45000);
    add_pair(16'h5555, 16'hAAAA);
    add_pair(16'hAAAA, 16'h5555);
    add_pair(16'd32800, 16'd32700);
    add_pair(16'd9700, 16'd32767);
    add_pair(16'd32768, 16'd55835);

    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(0, 9);
      mode = (mode == 0) ? 0 : (mode < 3) ? 1 : 2;
      // pause the sender once until every pending deviate has arrived
      add_pair(draw_uniform(mode), draw_uniform(mode), i == 450);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (all_sent && !in_busy);
    wait (deviates_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && deviates_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Timeout
  initial begin
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
